@@ hw/rtl/dscan_pkg.sv @@
package dscan_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RESULT_W       = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_SIGN   = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       has_number;
        logic                       overflowed;
        logic                       at_end;
    } out_t;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic       is_digit;
        logic       is_sign;
        logic       is_minus;
        logic [3:0] digit;
        logic       is_last;
    } tok_t;

endpackage

@@ hw/rtl/dscan_front.sv @@
module dscan_front
(
    input  logic              byte_valid,
    input  dscan_pkg::in_t    byte_data,
    output logic              byte_stall,
    input  logic              full,
    output logic              push,
    output dscan_pkg::tok_t   push_tok
);

    logic is_digit;
    logic is_plus;
    logic is_minus;

    always_comb
    begin
        is_digit = byte_data.text_byte inside {[dscan_pkg::CHAR_ZERO:dscan_pkg::CHAR_NINE]};
        is_plus  = (byte_data.text_byte == dscan_pkg::CHAR_PLUS);
        is_minus = (byte_data.text_byte == dscan_pkg::CHAR_MINUS);
    end

    always_comb
    begin
        push_tok.is_digit = is_digit;
        push_tok.is_sign  = is_plus | is_minus;
        push_tok.is_minus = is_minus;
        push_tok.digit    = is_digit ? byte_data.text_byte[3:0] : 4'd0;
        push_tok.is_last  = byte_data.is_last;
    end

    assign byte_stall = full;
    assign push       = byte_valid & ~full;

endmodule

@@ hw/rtl/dscan_queue.sv @@
module dscan_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dscan_pkg::tok_t   push_tok,
    output logic              full,
    output logic              tok_valid,
    output dscan_pkg::tok_t   tok,
    input  logic              pop
);

    localparam int AW = dscan_pkg::QUEUE_AW;

    dscan_pkg::tok_t entry_reg [dscan_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;

    assign full      = (count_reg == (AW+1)'(dscan_pkg::QUEUE_DEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> tok_valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(dscan_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ hw/rtl/dscan_back.sv @@
module dscan_back
#(
    parameter int VALUE_BITS = dscan_pkg::VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  dscan_pkg::tok_t   tok,
    output logic              pop,
    output logic              result_valid,
    output dscan_pkg::out_t   result_data,
    input  logic              result_stall
);

    localparam int VB = VALUE_BITS;
    localparam int RW = dscan_pkg::RESULT_W;
    localparam logic [VB-1:0] LIM = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] POS_MAX = {1'b0, {(VB-1){1'b1}}};

    logic [1:0]    mode_reg;
    logic          neg_reg;
    logic [VB-1:0] mag_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    dscan_pkg::out_t out_data_reg;

    logic [1:0]    mode_next;
    logic          neg_next;
    logic [VB-1:0] mag_next;
    logic          ovf_next;
    logic          emit;
    logic          has;

    logic [VB+3:0] acc;
    logic          over;
    logic [VB-1:0] add_mag;
    logic [VB-1:0] d_ext;

    logic [VB-1:0] sat_v;
    logic          sat_ovf;
    logic [RW-1:0] v_res;
    logic          slot_free;
    logic          fire;
    dscan_pkg::out_t out_next;

    // magnitude * 10 + digit, capped at 2^(VB-1)
    always_comb
    begin
        d_ext   = {{(VB-4){1'b0}}, tok.digit};
        acc     = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                  + {{VB{1'b0}}, tok.digit};
        over    = (acc > {4'b0000, LIM});
        add_mag = over ? LIM : acc[VB-1:0];
    end

    always_comb
    begin
        mode_next = mode_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        ovf_next  = ovf_reg;
        emit      = 1'b0;
        has       = 1'b0;
        case (mode_reg)
            dscan_pkg::MODE_DIGITS:
            begin
                if (tok.is_digit)
                begin
                    mag_next = add_mag;
                    ovf_next = ovf_reg | over;
                    emit     = tok.is_last;
                    has      = tok.is_last;
                end
                else
                begin
                    // terminating byte is consumed
                    emit = 1'b1;
                    has  = 1'b1;
                end
            end
            dscan_pkg::MODE_SIGN:
            begin
                if (tok.is_digit)
                begin
                    mode_next = dscan_pkg::MODE_DIGITS;
                    mag_next  = d_ext;
                    ovf_next  = 1'b0;
                end
                else
                begin
                    // drop the sign together with this byte
                    mode_next = dscan_pkg::MODE_SEARCH;
                    neg_next  = 1'b0;
                    mag_next  = '0;
                    ovf_next  = 1'b0;
                end
                emit = tok.is_last;
                has  = tok.is_last & tok.is_digit;
            end
            default:
            begin
                mode_next = dscan_pkg::MODE_SEARCH;
                neg_next  = 1'b0;
                mag_next  = '0;
                ovf_next  = 1'b0;
                if (tok.is_sign)
                begin
                    mode_next = dscan_pkg::MODE_SIGN;
                    neg_next  = tok.is_minus;
                end
                else if (tok.is_digit)
                begin
                    mode_next = dscan_pkg::MODE_DIGITS;
                    mag_next  = d_ext;
                end
                emit = tok.is_last;
                has  = tok.is_last & tok.is_digit;
            end
        endcase
    end

    always_comb
    begin
        if (neg_next)
        begin
            sat_v   = {VB{1'b0}} - mag_next;
            sat_ovf = ovf_next;
        end
        else if (mag_next[VB-1])
        begin
            sat_v   = POS_MAX;
            sat_ovf = 1'b1;
        end
        else
        begin
            sat_v   = mag_next;
            sat_ovf = ovf_next;
        end
    end

    if (VB >= RW)
    begin : g_trunc
        assign v_res = sat_v[RW-1:0];
    end
    else
    begin : g_sext
        assign v_res = {{(RW-VB){sat_v[VB-1]}}, sat_v};
    end

    always_comb
    begin
        out_next.value      = has ? signed'(v_res) : '0;
        out_next.has_number = has;
        out_next.overflowed = has & sat_ovf;
        out_next.at_end     = tok.is_last;
    end

    // a result-free byte never waits on the output slot
    assign slot_free = ~out_valid_reg | ~result_stall;
    assign fire      = tok_valid & (~emit | slot_free);
    assign pop       = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dscan_pkg::MODE_SEARCH;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (emit)
                begin
                    mode_reg <= dscan_pkg::MODE_SEARCH;
                    neg_reg  <= 1'b0;
                    mag_reg  <= '0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    mode_reg <= mode_next;
                    neg_reg  <= neg_next;
                    mag_reg  <= mag_next;
                    ovf_reg  <= ovf_next;
                end
            end
            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_data_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_emit_loads_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> out_valid_reg && mode_reg == dscan_pkg::MODE_SEARCH)
        else $error("emitted byte did not load result or clear scan state");

    a_mag_capped: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= LIM)
        else $error("magnitude above saturation limit");

    a_empty_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.has_number
        |-> out_data_reg.value == '0 && !out_data_reg.overflowed
            && out_data_reg.at_end)
        else $error("result without number carries data");

    a_search_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == dscan_pkg::MODE_SEARCH |-> mag_reg == '0 && !ovf_reg && !neg_reg)
        else $error("search mode with stale number state");

endmodule

@@ hw/rtl/decimal_integer_scanner.sv @@
// Decimal integer scanner: pulls signed decimal numbers out of an ASCII stream.
// Byte channel: byte_valid / byte_stall / byte_data (text_byte, is_last).
// Result channel: result_valid / result_stall / result_data (value, has_number,
// overflowed, at_end). A byte transfers when valid is high and stall is low.
// One byte is taken per clock while the queue is not full. Each byte is
// classified on entry and written to a four-entry queue; the scan unit reads
// the queue head and does the multiply-by-ten-add on it, so sustained rate is
// one byte per cycle while no held result blocks the scan unit.
// The byte that ends a number (or the last-marked byte) passes the queue entry
// register, then the scan unit's result register, before result_valid rises.
// Values saturate to the VALUE_BITS signed range and are returned in 32 bits.
// Reset clears the queue, the scan state and the result valid flag.
// While the receiver stalls, the result is held; bytes that make no result
// keep flowing, and byte_stall rises only once the queue has filled.
module decimal_integer_scanner
#(
    parameter int VALUE_BITS = dscan_pkg::VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  dscan_pkg::in_t    byte_data,
    output logic              byte_stall,
    output logic              result_valid,
    output dscan_pkg::out_t   result_data,
    input  logic              result_stall
);

    logic            full;
    logic            push;
    dscan_pkg::tok_t push_tok;
    logic            tok_valid;
    dscan_pkg::tok_t tok;
    logic            pop;

    dscan_front u_front
    (
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_stall (byte_stall),
        .full       (full),
        .push       (push),
        .push_tok   (push_tok)
    );

    dscan_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .pop       (pop)
    );

    dscan_back
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .pop          (pop),
        .result_valid (result_valid),
        .result_data  (result_data),
        .result_stall (result_stall)
    );

endmodule
